[sv/lfpn_pkg.sv]
// Package for the normalized line-through-two-points core: widths and state type.
package lfpn_pkg;

    localparam int COORD_WIDTH = 31;
    localparam int RAW_WIDTH   = COORD_WIDTH + 1;
    localparam int WIDE_WIDTH  = 64;
    localparam int CNT_WIDTH   = 7;
    localparam int SHIFT_WIDTH = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[sv/line_from_points_normalize_core.sv]
// Canonical integer line A*x+B*y+C=0 through two points, gcd normalized.
// Steps: two shift-and-add cross products (px*qy, then py*qx subtracted), then binary gcd
// steps, then three restoring divisions of |A|, |B| and |C| by the gcd; equal points skip
// straight from the check to the result.
// Throughput: one word at a time; busy stays high until the result strobe is issued.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid.
module line_from_points_normalize_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lfpn_pkg::COORD_WIDTH-1:0]  i_first_x,
    input  logic [lfpn_pkg::COORD_WIDTH-1:0]  i_first_y,
    input  logic [lfpn_pkg::COORD_WIDTH-1:0]  i_second_x,
    input  logic [lfpn_pkg::COORD_WIDTH-1:0]  i_second_y,
    output logic                              o_valid,
    output logic [30:0]                       o_coef_a,
    output logic [31:0]                       o_coef_b,
    output logic [62:0]                       o_coef_c,
    output logic                              o_degenerate
);
    import lfpn_pkg::*;

    localparam logic [CNT_WIDTH-1:0] MulLast = CNT_WIDTH'(COORD_WIDTH - 1);
    localparam logic [CNT_WIDTH-1:0] DivLast = CNT_WIDTH'(WIDE_WIDTH - 1);

    t_state r_state, n_state;

    logic [COORD_WIDTH-1:0] r_py, n_py, r_qx, n_qx;
    logic [RAW_WIDTH-1:0]   r_a, n_a, r_b, n_b;
    logic [WIDE_WIDTH-1:0]  r_mcand, n_mcand, r_acc, n_acc;
    logic [COORD_WIDTH-1:0] r_mplier, n_mplier;
    logic                   r_phase, n_phase;
    logic [CNT_WIDTH-1:0]   r_cnt, n_cnt;
    logic [1:0]             r_pass, n_pass;
    logic [WIDE_WIDTH-1:0]  r_u, n_u, r_v, n_v, r_g, n_g;
    logic [SHIFT_WIDTH-1:0] r_k, n_k;
    logic [WIDE_WIDTH-1:0]  r_ma, n_ma, r_mb, n_mb, r_mc, n_mc;
    logic [WIDE_WIDTH-1:0]  r_dvd, n_dvd, r_rem, n_rem;
    logic [WIDE_WIDTH-1:0]  r_qa, n_qa, r_qb, n_qb;
    logic                   r_valid, n_valid;
    logic [30:0]            r_oa, n_oa;
    logic [31:0]            r_ob, n_ob;
    logic [62:0]            r_oc, n_oc;
    logic                   r_degen, n_degen;

    logic [RAW_WIDTH-1:0]  in_a, in_b;
    logic [WIDE_WIDTH-1:0] term, gcd_res, div_try, a_ext, b_ext;
    logic                  mul_sub, flip, neg_b, neg_c;
    logic [WIDE_WIDTH-1:0] qc_signed;
    logic [31:0]           qb_signed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_py <= n_py; r_qx <= n_qx;
        r_a <= n_a; r_b <= n_b;
        r_mcand <= n_mcand; r_acc <= n_acc; r_mplier <= n_mplier; r_phase <= n_phase;
        r_cnt <= n_cnt; r_pass <= n_pass;
        r_u <= n_u; r_v <= n_v; r_g <= n_g; r_k <= n_k;
        r_ma <= n_ma; r_mb <= n_mb; r_mc <= n_mc;
        r_dvd <= n_dvd; r_rem <= n_rem; r_qa <= n_qa; r_qb <= n_qb;
        r_oa <= n_oa; r_ob <= n_ob; r_oc <= n_oc; r_degen <= n_degen;
    end

    always_comb begin
        n_state = r_state;
        n_py = r_py; n_qx = r_qx;
        n_a = r_a; n_b = r_b;
        n_mcand = r_mcand; n_acc = r_acc; n_mplier = r_mplier; n_phase = r_phase;
        n_cnt = r_cnt; n_pass = r_pass;
        n_u = r_u; n_v = r_v; n_g = r_g; n_k = r_k;
        n_ma = r_ma; n_mb = r_mb; n_mc = r_mc;
        n_dvd = r_dvd; n_rem = r_rem; n_qa = r_qa; n_qb = r_qb;
        n_oa = r_oa; n_ob = r_ob; n_oc = r_oc; n_degen = r_degen;
        n_valid = 1'b0;

        in_a = {i_first_y[COORD_WIDTH-1], i_first_y} - {i_second_y[COORD_WIDTH-1], i_second_y};
        in_b = {i_second_x[COORD_WIDTH-1], i_second_x} - {i_first_x[COORD_WIDTH-1], i_first_x};
        term    = r_mplier[0] ? r_mcand : '0;
        mul_sub = (r_cnt == MulLast) ^ r_phase;
        gcd_res = (r_u | r_v) << r_k;
        div_try = {r_rem[WIDE_WIDTH-2:0], r_dvd[WIDE_WIDTH-1]};
        a_ext = {{(WIDE_WIDTH-RAW_WIDTH){r_a[RAW_WIDTH-1]}}, r_a};
        b_ext = {{(WIDE_WIDTH-RAW_WIDTH){r_b[RAW_WIDTH-1]}}, r_b};
        flip  = r_a[RAW_WIDTH-1] || (r_a == '0 && r_b[RAW_WIDTH-1]);
        neg_b = r_b[RAW_WIDTH-1] ^ flip;
        neg_c = r_acc[WIDE_WIDTH-1] ^ flip;
        qb_signed = neg_b ? (32'd0 - r_qb[31:0]) : r_qb[31:0];
        qc_signed = neg_c ? (WIDE_WIDTH'(0) - r_dvd) : r_dvd;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_py = i_first_y; n_qx = i_second_x;
                    n_a = in_a; n_b = in_b;
                    // first product: px * qy
                    n_mcand  = {{(WIDE_WIDTH-COORD_WIDTH){i_first_x[COORD_WIDTH-1]}}, i_first_x};
                    n_mplier = i_second_y;
                    n_acc = '0; n_phase = 1'b0; n_cnt = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_acc = mul_sub ? (r_acc - term) : (r_acc + term);
                n_mcand = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MulLast) begin
                    n_cnt = '0;
                    if (!r_phase) begin
                        // second product: py * qx, subtracted
                        n_phase = 1'b1;
                        n_mcand = {{(WIDE_WIDTH-COORD_WIDTH){r_py[COORD_WIDTH-1]}}, r_py};
                        n_mplier = r_qx;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_ma = r_a[RAW_WIDTH-1] ? (WIDE_WIDTH'(0) - a_ext) : a_ext;
                n_mb = r_b[RAW_WIDTH-1] ? (WIDE_WIDTH'(0) - b_ext) : b_ext;
                n_mc = r_acc[WIDE_WIDTH-1] ? (WIDE_WIDTH'(0) - r_acc) : r_acc;
                n_u = n_ma; n_v = n_mb; n_k = '0; n_pass = 2'd0;
                if (r_a == '0 && r_b == '0) begin
                    n_oa = '0; n_ob = '0; n_oc = '0; n_degen = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (r_u == '0 || r_v == '0) begin
                    if (r_pass == 2'd0) begin
                        n_u = gcd_res; n_v = r_mc; n_k = '0; n_pass = 2'd1;
                    end else begin
                        n_g = gcd_res;
                        n_dvd = r_ma; n_rem = '0; n_cnt = '0; n_pass = 2'd0;
                        n_state = ST_DIV;
                    end
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1; n_v = r_v >> 1; n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = r_u - r_v;
                end else begin
                    n_v = r_v - r_u;
                end
            end
            ST_DIV: begin
                if (div_try >= r_g) begin
                    n_rem = div_try - r_g;
                    n_dvd = {r_dvd[WIDE_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = div_try;
                    n_dvd = {r_dvd[WIDE_WIDTH-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DivLast) begin
                    n_cnt = '0; n_rem = '0;
                    unique case (r_pass)
                        2'd0: begin n_qa = n_dvd; n_dvd = r_mb; n_pass = 2'd1; end
                        2'd1: begin n_qb = n_dvd; n_dvd = r_mc; n_pass = 2'd2; end
                        default: begin
                            n_pass = 2'd0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_degen) begin
                    n_oa = r_qa[30:0];
                    n_ob = qb_signed;
                    n_oc = qc_signed[62:0];
                end
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // clear the degenerate mark on a fresh word
        if (r_state == ST_IDLE && start) n_degen = 1'b0;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_coef_a     = r_oa;
    assign o_coef_b     = r_ob;
    assign o_coef_c     = r_oc;
    assign o_degenerate = r_degen;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("word accepted but not busy");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_coef_a == '0 && o_coef_b == '0 && o_coef_c == '0))
        else $error("degenerate result has nonzero coefficients");
    a_sign_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |-> (o_coef_a != '0 || (o_coef_b != '0 && !o_coef_b[31])))
        else $error("sign rule broken");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the gcd-normalized line-through-two-points core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpn_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;

    typedef logic [COORD_WIDTH-1:0] t_coord;

    typedef struct {
        logic [30:0] coef_a;
        logic [31:0] coef_b;
        logic [62:0] coef_c;
        logic        degenerate;
    } t_line;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord i_first_x = '0;
    t_coord i_first_y = '0;
    t_coord i_second_x = '0;
    t_coord i_second_y = '0;
    logic        o_valid;
    logic [30:0] o_coef_a;
    logic [31:0] o_coef_b;
    logic [62:0] o_coef_c;
    logic        o_degenerate;

    t_line line_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    send_idle_pct = 0;

    line_from_points_normalize_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .o_valid     (o_valid),
        .o_coef_a    (o_coef_a),
        .o_coef_b    (o_coef_b),
        .o_coef_c    (o_coef_c),
        .o_degenerate(o_degenerate)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint unsigned gcd_of(longint unsigned p, longint unsigned q);
        longint unsigned r;
        while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic t_line line_through(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
        longint px, py, qx, qy, a, b, c;
        longint unsigned ma, mb, mc, g, ra, rb, rc;
        logic flip, neg_b, neg_c;
        t_line res;
        px = longint'($signed(fx));
        py = longint'($signed(fy));
        qx = longint'($signed(sx));
        qy = longint'($signed(sy));
        a = py - qy;
        b = qx - px;
        c = px * qy - py * qx;
        if (a == 0 && b == 0) begin
            res.coef_a = '0;
            res.coef_b = '0;
            res.coef_c = '0;
            res.degenerate = 1'b1;
            return res;
        end
        ma = mag(a);
        mb = mag(b);
        mc = mag(c);
        g = gcd_of(gcd_of(ma, mb), mc);
        flip = (a < 0) || (a == 0 && b < 0);
        neg_b = (b < 0) != flip;
        neg_c = (c < 0) != flip;
        ra = ma / g;
        rb = mb / g;
        rc = mc / g;
        if (neg_b) rb = 64'd0 - rb;
        if (neg_c) rc = 64'd0 - rc;
        res.coef_a = ra[30:0];
        res.coef_b = rb[31:0];
        res.coef_c = rc[62:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    // Hold start high until the core takes the word; leave it high for a back-to-back send.
    task automatic send_points(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
        int gap;
        start <= 1'b1;
        i_first_x <= fx;
        i_first_y <= fy;
        i_second_x <= sx;
        i_second_y <= sy;
        do @(posedge i_clk); while (busy);
        line_q.push_back(line_through(fx, fy, sx, sy));
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_lines();
        start <= 1'b0;
        while (line_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 40)) - 20);
            default: return t_coord'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic test_directed();
        t_coord cmax, cmin;
        cmax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        cmin = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        send_idle_pct = 0;
        send_points('0, '0, '0, '0);
        send_points(cmax, cmax, cmax, cmax);
        send_points(cmin, cmin, cmin, cmin);
        send_points(cmin, cmin, cmax, cmax);
        send_points(cmax, cmax, cmin, cmin);
        send_points(cmin, cmax, cmax, cmin);
        send_points(cmax, cmin, cmin, cmax);
        send_points(cmin, cmax, cmin, cmin);
        send_points(cmax, cmin, cmax, cmax);
        send_points(cmin, cmin, cmax, cmin);
        send_points(cmax, cmax, cmin, cmax);
        send_points('0, '0, 31'd3, 31'd6);
        send_points(31'd5, 31'd7, 31'd5, 31'd7);
        send_points(31'd2, 31'd4, 31'd6, 31'd4);
        send_points(31'd6, 31'd4, 31'd2, 31'd4);
        send_points(31'd4, 31'd2, 31'd4, 31'd6);
        send_points(31'd4, 31'd6, 31'd4, 31'd2);
        send_points(31'd6, 31'd9, 31'd12, 31'd21);
        send_points(-31'sd3, 31'd1, 31'd7, -31'sd9);
        send_points(cmax, 31'd1, 31'd1, cmax);
        send_points(cmin, 31'd1, -31'sd1, cmin);
        wait_all_lines();
    endtask

    task automatic test_random(int count, int idle_pct);
        t_coord fx, fy, sx, sy;
        int mode, kind;
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 2);
            kind = $urandom_range(0, 19);
            fx = rand_coord(mode);
            fy = rand_coord(mode);
            sx = rand_coord(mode);
            sy = rand_coord(mode);
            if (kind == 0) begin
                sx = fx;
                sy = fy;
            end else if (kind == 1) begin
                sy = fy;
            end else if (kind == 2) begin
                sx = fx;
            end
            send_points(fx, fy, sx, sy);
            if (i == count / 2) wait_all_lines();
        end
        wait_all_lines();
    endtask

    always @(posedge i_clk) begin
        t_line want;
        if (i_rst_n && o_valid) begin
            if (line_q.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                want = line_q.pop_front();
                if (o_coef_a !== want.coef_a) begin
                    $error("coef_a expected %0d got %0d", want.coef_a, o_coef_a);
                    errors++;
                end
                if (o_coef_b !== want.coef_b) begin
                    $error("coef_b expected %0d got %0d",
                           $signed(want.coef_b), $signed(o_coef_b));
                    errors++;
                end
                if (o_coef_c !== want.coef_c) begin
                    $error("coef_c expected %0d got %0d",
                           $signed(want.coef_c), $signed(o_coef_c));
                    errors++;
                end
                if (o_degenerate !== want.degenerate) begin
                    $error("degenerate expected %0b got %0b", want.degenerate, o_degenerate);
                    errors++;
                end
            end
        end
    end

    // Count cycles with no handshake on either side; give up on a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(380, 30);
        test_random(380, 47);
        test_random(380, 0);
        wait_all_lines();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && line_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
